// ----- src/obrf_pkg.sv -----
// Shared types, constants and helpers for the overwriting byte ring FIFO.
// Used by every module of the block; depends on nothing.
package obrf_pkg;

    localparam int DATA_W         = 64;
    localparam int BYTE_W         = 8;
    localparam int ROW_BYTES      = 8;
    localparam int OFF_W          = 3;
    localparam int FILL_W         = 10;
    localparam int ACTION_W       = 2;
    localparam int ITEM_LOG2_W    = 2;
    localparam int RING_LOG2_W    = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 4;
    localparam int QDEPTH         = 2;
    localparam int DEF_RING_BYTES = 1024;
    localparam int MAX_ITEM_BYTES = 8;
    localparam int ITEM_LOG2_MAX  = $clog2(MAX_ITEM_BYTES + 1) - 1;
    localparam int MIN_RING_LOG2  = 3;

    localparam logic [ITEM_LOG2_W-1:0] RESET_ITEM_LOG2 = 2'd0;
    localparam logic [RING_LOG2_W-1:0] RESET_RING_LOG2 = 4'd10;

    // Action codes on the input channel
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 1'b1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_FLUSH,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] data;
    } cmd_t;

    // Byte lanes covered by one item of 2**lg bytes
    function automatic logic [ROW_BYTES-1:0] item_bytes_mask(input logic [ITEM_LOG2_W-1:0] lg);
        logic [ROW_BYTES-1:0] m;
        unique case (lg)
            2'd0: m = 8'h01;
            2'd1: m = 8'h03;
            2'd2: m = 8'h0F;
            2'd3: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// ----- src/obrf_front.sv -----
// Front stage of the ring FIFO: takes input items and classifies the action.
// Depends on obrf_pkg.
module obrf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [obrf_pkg::ACTION_W-1:0]   action,
    input  logic [obrf_pkg::DATA_W-1:0]     push_data,
    output logic                            cmd_valid,
    input  logic                            cmd_stall,
    output obrf_pkg::cmd_t                  cmd
);
    import obrf_pkg::*;

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t cmd_reg;
    op_t  op_dec;
    logic load;

    always_comb
    begin
        unique case (action)
            ACT_PUSH:  op_dec = OP_PUSH;
            ACT_POP:   op_dec = OP_POP;
            ACT_FLUSH: op_dec = OP_FLUSH;
            ACT_NONE:  op_dec = OP_NOP;
        endcase
    end

    assign in_stall = front_valid_reg && cmd_stall;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (load)
        begin
            front_valid_next = 1'b1;
        end
        else if (!cmd_stall)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg.op   <= op_dec;
            cmd_reg.data <= push_data;
        end
    end

    assign cmd_valid = front_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ----- src/obrf_queue.sv -----
// Short command queue between the front and back stages of the ring FIFO.
// Depends on obrf_pkg.
module obrf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  obrf_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  logic            out_stall,
    output obrf_pkg::cmd_t  out_cmd
);
    import obrf_pkg::*;

    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;
    logic              enq;
    logic              deq;

    assign in_stall  = (count_reg == QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign enq       = in_valid && !in_stall;
    assign deq       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- src/obrf_back.sv -----
// Back stage of the ring FIFO: pointers, byte-lane store, config and result register.
// Depends on obrf_pkg.
module obrf_back #(
    parameter int RING_BYTES = obrf_pkg::DEF_RING_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [obrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [obrf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  obrf_pkg::cmd_t                    cmd,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              status,
    output logic [obrf_pkg::DATA_W-1:0]       pop_data,
    output logic                              dropped_oldest,
    output logic [obrf_pkg::FILL_W-1:0]       fill_bytes,
    output logic                              is_empty,
    output logic                              is_full
);
    import obrf_pkg::*;

    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int ROWS   = RING_BYTES / ROW_BYTES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WIDE_W = (PTR_W > FILL_W) ? PTR_W : FILL_W;

    // configuration
    logic [ITEM_LOG2_W-1:0] item_cfg_reg;
    logic [RING_LOG2_W-1:0] ring_cfg_reg;
    logic [ITEM_LOG2_W-1:0] item_log2;
    logic [4:0]             ring_log2;
    logic [PTR_W:0]         ring_len;
    logic [PTR_W-1:0]       ring_mask;
    logic [3:0]             isz_wide;
    logic [PTR_W-1:0]       isz;

    // pointers
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] head_adv;
    logic [PTR_W-1:0] tail_adv;
    logic             ring_empty;

    // store
    logic [DATA_W-1:0]    mem [ROWS];
    logic [DATA_W-1:0]    rd_data_reg;
    logic [ROW_W-1:0]     head_row;
    logic [ROW_W-1:0]     tail_row;
    logic [OFF_W-1:0]     head_off;
    logic [ROW_BYTES-1:0] wr_be;
    logic [DATA_W-1:0]    wr_row;
    logic                 wr_en;
    logic                 rd_en;

    // result register
    logic                   out_valid_reg;
    logic                   status_reg;
    logic                   dropped_reg;
    logic                   empty_reg;
    logic                   full_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic                   popped_reg;
    logic [OFF_W-1:0]       pop_off_reg;
    logic [ITEM_LOG2_W-1:0] pop_log2_reg;

    logic                   status_next;
    logic                   dropped_next;
    logic                   popped_next;
    logic [PTR_W-1:0]       fill_diff;
    logic [WIDE_W-1:0]      fill_wide;
    logic                   empty_next;
    logic                   full_next;
    logic                   take;

    logic [DATA_W-1:0]      pop_shifted;
    logic [DATA_W-1:0]      pop_bits;
    logic [ROW_BYTES-1:0]   pop_lanes;

    // Clamp the item and ring sizes to what the store supports
    always_comb
    begin
        item_log2 = (item_cfg_reg > ITEM_LOG2_W'(ITEM_LOG2_MAX))
                    ? ITEM_LOG2_W'(ITEM_LOG2_MAX) : item_cfg_reg;
        if (ring_cfg_reg < RING_LOG2_W'(MIN_RING_LOG2))
        begin
            ring_log2 = 5'(MIN_RING_LOG2);
        end
        else if (5'(ring_cfg_reg) > 5'(PTR_W))
        begin
            ring_log2 = 5'(PTR_W);
        end
        else
        begin
            ring_log2 = 5'(ring_cfg_reg);
        end
    end

    assign ring_len  = (PTR_W + 1)'(1) << ring_log2;
    assign ring_mask = ring_len[PTR_W-1:0] - 1'b1;
    assign isz_wide  = 4'd1 << item_log2;
    assign isz       = PTR_W'(isz_wide);

    assign head_adv   = (head_reg + isz) & ring_mask;
    assign tail_adv   = (tail_reg + isz) & ring_mask;
    assign ring_empty = (head_reg == tail_reg);

    assign cmd_stall = out_valid_reg && out_stall;
    assign take      = cmd_valid && !cmd_stall;

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        status_next  = 1'b0;
        dropped_next = 1'b0;
        popped_next  = 1'b0;
        priority if (cfg_we)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else if (take)
        begin
            unique case (cmd.op)
                OP_PUSH:
                begin
                    wr_en     = 1'b1;
                    head_next = head_adv;
                    if (head_adv == tail_reg)
                    begin
                        tail_next    = tail_adv;
                        dropped_next = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (ring_empty)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        popped_next = 1'b1;
                        tail_next   = tail_adv;
                    end
                end
                OP_FLUSH:
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                OP_NOP:
                begin
                    head_next = head_reg;
                end
            endcase
        end
        else
        begin
            head_next = head_reg;
        end
    end

    // Fill and flags as seen after this item
    assign fill_diff  = (head_next - tail_next) & ring_mask;
    assign fill_wide  = WIDE_W'(fill_diff);
    assign empty_next = (head_next == tail_next);
    assign full_next  = (((head_next + isz) & ring_mask) == tail_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_cfg_reg <= RESET_ITEM_LOG2;
            ring_cfg_reg <= RESET_RING_LOG2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ITEM_SIZE: item_cfg_reg <= cfg_data[ITEM_LOG2_W-1:0];
                CFG_RING_SIZE: ring_cfg_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            pop_log2_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
                pop_log2_reg  <= item_log2;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg   <= status_next;
            dropped_reg  <= dropped_next;
            popped_reg   <= popped_next;
            fill_reg     <= fill_wide[FILL_W-1:0];
            empty_reg    <= empty_next;
            full_reg     <= full_next;
            pop_off_reg  <= tail_reg[OFF_W-1:0];
        end
    end

    // Items sit aligned inside one row, so one row access covers an item
    assign head_row = ROW_W'(head_reg >> OFF_W);
    assign tail_row = ROW_W'(tail_reg >> OFF_W);
    assign head_off = head_reg[OFF_W-1:0];
    assign wr_be    = item_bytes_mask(item_log2) << head_off;
    assign wr_row   = cmd.data << {head_off, 3'b000};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int b = 0; b < ROW_BYTES; b++)
            begin
                if (wr_be[b])
                begin
                    mem[head_row][b*BYTE_W +: BYTE_W] <= wr_row[b*BYTE_W +: BYTE_W];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[tail_row];
        end
    end

    // Align the popped row to byte 0 and clear lanes past the item
    assign pop_lanes   = item_bytes_mask(pop_log2_reg);
    assign pop_shifted = rd_data_reg >> {pop_off_reg, 3'b000};

    always_comb
    begin
        for (int b = 0; b < ROW_BYTES; b++)
        begin
            pop_bits[b*BYTE_W +: BYTE_W] = {BYTE_W{pop_lanes[b]}};
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign pop_data       = popped_reg ? (pop_shifted & pop_bits) : '0;
    assign dropped_oldest = dropped_reg;
    assign fill_bytes     = fill_reg;
    assign is_empty       = empty_reg;
    assign is_full        = full_reg;

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ((head_reg & ~ring_mask) == '0) && ((tail_reg & ~ring_mask) == '0))
        else $error("pointer outside the ring");

    a_ptr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ((head_reg & (isz - 1'b1)) == '0) && ((tail_reg & (isz - 1'b1)) == '0))
        else $error("pointer off an item boundary");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !cfg_we && (cmd.op == OP_POP) && ring_empty)
        |=> (out_valid_reg && status_reg && !popped_reg))
        else $error("pop on empty ring not reported");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !cfg_we && (cmd.op == OP_PUSH) && (head_adv == tail_reg))
        |=> (dropped_reg && full_reg))
        else $error("overwriting push did not leave ring full");

endmodule

// ----- src/overwriting_byte_ring_fifo.sv -----
// Overwriting byte ring FIFO: from input accept to result valid an item passes the front
// register (loaded at accept), then the command queue, then back execute into the result.
// Throughput is one item per cycle while out_stall is low; a held result stalls the back stage.
// Reset clears pointers, front and queue valid state and the result valid bit; item size 1 byte, ring 1024 bytes.
// The store is not swept on reset or flush: only bytes pushed since then are ever read.
module overwriting_byte_ring_fifo #(
    parameter int RING_BYTES = obrf_pkg::DEF_RING_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [obrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [obrf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [obrf_pkg::ACTION_W-1:0]     action,
    input  logic [obrf_pkg::DATA_W-1:0]       push_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              status,
    output logic [obrf_pkg::DATA_W-1:0]       pop_data,
    output logic                              dropped_oldest,
    output logic [obrf_pkg::FILL_W-1:0]       fill_bytes,
    output logic                              is_empty,
    output logic                              is_full
);
    import obrf_pkg::*;

    // Front to queue: one classified item held until the queue has room
    logic front_valid;
    logic front_stall;
    cmd_t front_cmd;

    // Queue to back: the back stage pulls when its result register frees up
    logic queue_valid;
    logic queue_stall;
    cmd_t queue_cmd;

    // Latch the item and decode its action
    obrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .push_data (push_data),
        .cmd_valid (front_valid),
        .cmd_stall (front_stall),
        .cmd       (front_cmd)
    );

    // Decouple the front from stalls at the result side
    obrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_stall  (front_stall),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_stall (queue_stall),
        .out_cmd   (queue_cmd)
    );

    // Advance pointers, write or read the row store and register the result;
    // a configuration write also flushes both pointers
    obrf_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd_valid      (queue_valid),
        .cmd_stall      (queue_stall),
        .cmd            (queue_cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .pop_data       (pop_data),
        .dropped_oldest (dropped_oldest),
        .fill_bytes     (fill_bytes),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

endmodule
